FILE: rtl/core/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// shared types and constants of the string escape decoder
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int MAX_HEX_DIGITS = 6;
  localparam int ACC_W = (4 * MAX_HEX_DIGITS > 8) ? 4 * MAX_HEX_DIGITS : 8;
  localparam int CNT_W = $clog2(MAX_HEX_DIGITS + 1);

  localparam int GRP_N = 4;
  localparam int GRP_IDX_W = $clog2(GRP_N);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_OK     = 2'd1;
  localparam logic [1:0] KIND_UNTERM = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  typedef struct packed {
    logic [GRP_N-1:0][7:0] bytes;
    logic [1:0]            kind;
    logic [GRP_IDX_W-1:0]  last_idx;
  } sed_group_t;

  typedef struct packed {
    logic       valid;
    sed_group_t group;
  } sed_push_t;

endpackage

FILE: rtl/core/sed_in_if.sv
// ----------------------------------------------------------------------------
// sed_in_if
// source byte channel of the string escape decoder
// ----------------------------------------------------------------------------
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

FILE: rtl/core/sed_out_if.sv
// ----------------------------------------------------------------------------
// sed_out_if
// result channel of the string escape decoder
// ----------------------------------------------------------------------------
interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

FILE: rtl/core/sed_decode.sv
// ----------------------------------------------------------------------------
// sed_decode
// escape state machine: turns one source byte into a group of up to four
// results in the same cycle
// ----------------------------------------------------------------------------
module sed_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output sed_pkg::sed_push_t push
);
  import sed_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [31:0] CP_MAX  = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO = 32'h0000_D800;
  localparam logic [31:0] SURR_HI = 32'h0000_DFFF;
  localparam logic [31:0] LIM_1B  = 32'h0000_007F;
  localparam logic [31:0] LIM_2B  = 32'h0000_07FF;
  localparam logic [31:0] LIM_3B  = 32'h0000_FFFF;
  localparam logic [7:0]  LEAD_2B = 8'hC0;
  localparam logic [7:0]  LEAD_3B = 8'hE0;
  localparam logic [7:0]  LEAD_4B = 8'hF0;
  localparam logic [7:0]  CONT    = 8'h80;

  typedef enum logic [2:0] {
    M_BODY, M_ESC, M_HEX1, M_HEX2, M_UOPEN, M_UDIG
  } mode_t;

  mode_t            mode, mode_next;
  logic [ACC_W-1:0] code_accum, code_accum_next;
  logic [CNT_W-1:0] hex_count, hex_count_next;

  logic       hex_ok;
  logic [3:0] hex_val;
  logic [31:0] accum_wide;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic sed_group_t single(input logic [7:0] b, input logic [1:0] k);
    sed_group_t g;
    g = '0;
    g.bytes[0] = b;
    g.kind = k;
    return g;
  endfunction

  function automatic sed_group_t encode(input logic [31:0] cp);
    sed_group_t g;
    g = '0;
    g.kind = KIND_DATA;
    if (cp <= LIM_1B) begin
      g.bytes[0] = cp[7:0];
      g.last_idx = GRP_IDX_W'(0);
    end else if (cp <= LIM_2B) begin
      g.bytes[0] = LEAD_2B | {3'b0, cp[10:6]};
      g.bytes[1] = CONT | {2'b0, cp[5:0]};
      g.last_idx = GRP_IDX_W'(1);
    end else if (cp <= LIM_3B) begin
      g.bytes[0] = LEAD_3B | {4'b0, cp[15:12]};
      g.bytes[1] = CONT | {2'b0, cp[11:6]};
      g.bytes[2] = CONT | {2'b0, cp[5:0]};
      g.last_idx = GRP_IDX_W'(2);
    end else begin
      g.bytes[0] = LEAD_4B | {5'b0, cp[20:18]};
      g.bytes[1] = CONT | {2'b0, cp[17:12]};
      g.bytes[2] = CONT | {2'b0, cp[11:6]};
      g.bytes[3] = CONT | {2'b0, cp[5:0]};
      g.last_idx = GRP_IDX_W'(3);
    end
    return g;
  endfunction

  assign {hex_ok, hex_val} = hex_value(in_byte);
  assign accum_wide = 32'(code_accum);

  always_comb begin
    mode_next        = mode;
    code_accum_next  = code_accum;
    hex_count_next   = hex_count;
    push             = '0;
    if (accept) begin
      unique case (mode)
        M_BODY: begin
          unique case (in_byte) inside
            CH_DQUOTE: begin
              push = {1'b1, single(8'h00, KIND_OK)};
            end
            CH_NUL: begin
              push = {1'b1, single(8'h00, KIND_UNTERM)};
            end
            CH_BSLASH: begin
              mode_next = M_ESC;
            end
            default: begin
              push = {1'b1, single(in_byte, KIND_DATA)};
            end
          endcase
        end
        M_ESC: begin
          mode_next = M_BODY;
          unique case (in_byte) inside
            CH_NL: ;
            CH_N: push = {1'b1, single(CH_NL, KIND_DATA)};
            CH_R: push = {1'b1, single(CH_CR, KIND_DATA)};
            CH_T: push = {1'b1, single(CH_TAB, KIND_DATA)};
            CH_BSLASH, CH_SQUOTE, CH_DQUOTE: push = {1'b1, single(in_byte, KIND_DATA)};
            CH_X: begin
              mode_next       = M_HEX1;
              code_accum_next = '0;
            end
            CH_U: mode_next = M_UOPEN;
            default: begin
              push             = {1'b1, single(8'h00, KIND_BAD)};
              code_accum_next  = '0;
              hex_count_next   = '0;
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (!hex_ok) begin
            push             = {1'b1, single(8'h00, KIND_BAD)};
            mode_next        = M_BODY;
            code_accum_next  = '0;
            hex_count_next   = '0;
          end else if (mode == M_HEX1) begin
            mode_next       = M_HEX2;
            code_accum_next = ACC_W'({code_accum[3:0], hex_val});
          end else begin
            push             = {1'b1, encode({24'b0, code_accum[3:0], hex_val})};
            mode_next        = M_BODY;
            code_accum_next  = '0;
            hex_count_next   = '0;
          end
        end
        M_UOPEN: begin
          if (in_byte == CH_LBRACE) begin
            mode_next        = M_UDIG;
            code_accum_next  = '0;
            hex_count_next   = '0;
          end else begin
            push             = {1'b1, single(8'h00, KIND_BAD)};
            mode_next        = M_BODY;
            code_accum_next  = '0;
            hex_count_next   = '0;
          end
        end
        M_UDIG: begin
          mode_next        = M_BODY;
          code_accum_next  = '0;
          hex_count_next   = '0;
          if (in_byte == CH_RBRACE) begin
            if (hex_count == '0 || accum_wide > CP_MAX ||
                (accum_wide >= SURR_LO && accum_wide <= SURR_HI)) begin
              push = {1'b1, single(8'h00, KIND_BAD)};
            end else begin
              push = {1'b1, encode(accum_wide)};
            end
          end else if (!hex_ok || hex_count >= CNT_W'(MAX_HEX_DIGITS)) begin
            push = {1'b1, single(8'h00, KIND_BAD)};
          end else begin
            mode_next        = M_UDIG;
            code_accum_next  = {code_accum[ACC_W-5:0], hex_val};
            hex_count_next   = hex_count + 1'b1;
          end
        end
        default: begin
          mode_next        = M_BODY;
          code_accum_next  = '0;
          hex_count_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_BODY;
      code_accum  <= '0;
      hex_count   <= '0;
    end else begin
      mode        <= mode_next;
      code_accum  <= code_accum_next;
      hex_count   <= hex_count_next;
    end
  end

endmodule

FILE: rtl/core/sed_queue.sv
// ----------------------------------------------------------------------------
// sed_queue
// result group queue: holds decoded groups and hands out one result per
// transfer
// ----------------------------------------------------------------------------
module sed_queue (
  input  logic              clk,
  input  logic              rst,
  input  sed_pkg::sed_push_t push,
  output logic              ready,
  sed_out_if.source         result
);
  import sed_pkg::*;

  sed_group_t           grp [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic [GRP_IDX_W-1:0] sub;

  sed_group_t head;
  logic       pop;
  logic       pop_last;
  logic       at_last;

  assign head     = grp[rd_ptr];
  assign at_last  = (sub == head.last_idx);
  assign pop      = result.valid && result.ready;
  assign pop_last = pop && at_last;
  assign ready    = (count != Q_CNT_W'(Q_DEPTH));

  assign result.valid    = (count != '0);
  assign result.out_byte = head.bytes[sub];
  assign result.kind     = head.kind;
  assign result.last     = at_last;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      grp[wr_ptr] <= push.group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_last) begin
        rd_ptr <= rd_ptr + 1'b1;
        sub    <= '0;
      end else if (pop) begin
        sub <= sub + 1'b1;
      end
      count <= count + Q_CNT_W'(push.valid) - Q_CNT_W'(pop_last);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> ready)
    else $error("group written into a full queue");

  a_sub_in_group: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> sub <= head.last_idx)
    else $error("result index beyond head group");

  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !at_last) |=> result.valid)
    else $error("group ended before its last result");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind != KIND_DATA) |-> (result.last && result.out_byte == 8'h00))
    else $error("status result not a single zero result");
`endif

endmodule

FILE: rtl/core/string_escape_utf8_decoder.sv
// ----------------------------------------------------------------------------
// string_escape_utf8_decoder
// decodes escapes of a string literal body and writes code points as utf-8
// ----------------------------------------------------------------------------
//  channel  role    payload                    per transfer
//  body     sink    in_byte                    one source byte
//  result   source  out_byte, kind, last       one result
//
//  a byte is decoded in the cycle it is taken; its group of 0 to 4 results
//  is queued and leaves one result per cycle while the result channel is ready
//  one byte per cycle is taken while the four-group queue has room
//  synchronous reset returns the escape state to normal body, empties the queue
//  a stalled result channel fills the queue, then body ready falls
// ----------------------------------------------------------------------------
module string_escape_utf8_decoder (
  input  logic      clk,
  input  logic      rst,
  sed_in_if.sink    body,
  sed_out_if.source result
);
  import sed_pkg::*;

  sed_push_t push;
  logic      q_ready;
  logic      accept;

  assign body.ready = q_ready;
  assign accept     = body.valid && q_ready;

  sed_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (body.in_byte),
    .push    (push)
  );

  sed_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .ready  (q_ready),
    .result (result)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the string escape decoder: a short table of directed
// bytes, then random literal fragments (escapes, hex and brace code points,
// broken escapes, ends, noise), each with its expected results set byte by byte and compared with
// every result transfer under random stalls on both channels
// ----------------------------------------------------------------------------
module testbench;
  import sed_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int ITEM_TARGET     = 420;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 60;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 16;

  typedef enum logic [2:0] {
    MD_BODY, MD_ESC, MD_HEX1, MD_HEX2, MD_UOPEN, MD_UDIG
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] kind;
    logic       last;
  } utf8_res_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       fixed;
    logic [7:0] value;
    logic [1:0] kind;
  } stim_row_t;

  logic clk;
  logic rst;

  sed_in_if  body_if ();
  sed_out_if result_if ();

  string_escape_utf8_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .body   (body_if),
    .result (result_if)
  );

  scan_mode_t  scan_mode;
  logic [31:0] code_acc;
  int          digits;
  utf8_res_t   step_q[$];
  utf8_res_t   decoded_q[$];
  logic [7:0]  src_q[$];
  int          sent;
  int          results_seen;
  int          mismatches;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // decoder prediction
  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void scan_reset();
    scan_mode = MD_BODY;
    code_acc  = '0;
    digits    = 0;
  endfunction

  function automatic void emit(logic [7:0] v, logic [1:0] k);
    step_q.push_back({v, k, 1'b0});
  endfunction

  function automatic void end_literal(logic [1:0] k);
    scan_reset();
    emit(CH_NUL, k);
  endfunction

  function automatic void put_code_point(logic [31:0] cp);
    if (cp <= 32'h7F) begin
      emit(cp[7:0], KIND_DATA);
    end else if (cp <= 32'h7FF) begin
      emit(8'hC0 | cp[10:6], KIND_DATA);
      emit(8'h80 | cp[5:0], KIND_DATA);
    end else if (cp <= 32'hFFFF) begin
      emit(8'hE0 | cp[15:12], KIND_DATA);
      emit(8'h80 | cp[11:6], KIND_DATA);
      emit(8'h80 | cp[5:0], KIND_DATA);
    end else begin
      emit(8'hF0 | cp[20:18], KIND_DATA);
      emit(8'h80 | cp[17:12], KIND_DATA);
      emit(8'h80 | cp[11:6], KIND_DATA);
      emit(8'h80 | cp[5:0], KIND_DATA);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int          h;
    logic [31:0] v;
    utf8_res_t   r;
    step_q.delete();
    h = hex_val(b);
    case (scan_mode)
      MD_BODY: begin
        if (b == CH_QUOTE) end_literal(KIND_OK);
        else if (b == CH_NUL) end_literal(KIND_UNTERM);
        else if (b == CH_BSLASH) scan_mode = MD_ESC;
        else emit(b, KIND_DATA);
      end
      MD_ESC: begin
        scan_mode = MD_BODY;
        case (b)
          CH_NL: ;
          "n": emit(CH_NL, KIND_DATA);
          "r": emit(CH_CR, KIND_DATA);
          "t": emit(CH_TAB, KIND_DATA);
          CH_BSLASH, CH_APOS, CH_QUOTE: emit(b, KIND_DATA);
          "x": begin
            scan_mode = MD_HEX1;
            code_acc  = '0;
          end
          "u": scan_mode = MD_UOPEN;
          default: end_literal(KIND_BAD);
        endcase
      end
      MD_HEX1, MD_HEX2: begin
        if (h < 0) begin
          end_literal(KIND_BAD);
        end else begin
          code_acc = {24'd0, code_acc[3:0], 4'(h)};
          if (scan_mode == MD_HEX1) begin
            scan_mode = MD_HEX2;
          end else begin
            v = code_acc;
            scan_reset();
            put_code_point(v);
          end
        end
      end
      MD_UOPEN: begin
        if (b != CH_LBRACE) begin
          end_literal(KIND_BAD);
        end else begin
          scan_mode = MD_UDIG;
          code_acc  = '0;
          digits    = 0;
        end
      end
      MD_UDIG: begin
        if (b == CH_RBRACE) begin
          if (digits == 0 || code_acc > 32'h10FFFF ||
              (code_acc >= 32'hD800 && code_acc <= 32'hDFFF)) begin
            end_literal(KIND_BAD);
          end else begin
            v = code_acc;
            scan_reset();
            put_code_point(v);
          end
        end else if (h < 0 || digits >= MAX_HEX_DIGITS) begin
          end_literal(KIND_BAD);
        end else begin
          code_acc = {code_acc[27:0], 4'(h)};
          digits++;
        end
      end
      default: scan_reset();
    endcase
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
  endfunction

  // stimulus helpers
  function automatic stim_row_t row_known(logic [7:0] b, logic [7:0] v, logic [1:0] k);
    return {b, 1'b1, v, k};
  endfunction

  function automatic stim_row_t row_pred(logic [7:0] b);
    return {b, 1'b0, 8'h00, KIND_DATA};
  endfunction

  function automatic int pick_wait(int n);
    case ((n / 37) % 3)
      0: return $urandom_range(0, 15);
      1: return 0;
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic void push_hex(logic [31:0] v, int ndig);
    for (int i = ndig - 1; i >= 0; i--) begin
      src_q.push_back(hex_char(int'((v >> (4 * i)) & 32'hF)));
    end
  endfunction

  function automatic int min_digits(logic [31:0] v);
    int n;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    return n;
  endfunction

  function automatic logic [31:0] pick_code_point();
    logic [31:0] cp;
    case ($urandom_range(0, 4))
      0: cp = $urandom_range(0, 32'h7F);
      1: cp = $urandom_range(32'h80, 32'h7FF);
      2: begin
        cp = $urandom_range(32'h800, 32'hFFFF);
        if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp ^ 32'h8000;
      end
      3: cp = $urandom_range(32'h10000, 32'h10FFFF);
      default: begin
        case ($urandom_range(0, 9))
          0: cp = 32'h0;
          1: cp = 32'h7F;
          2: cp = 32'h80;
          3: cp = 32'h7FF;
          4: cp = 32'h800;
          5: cp = 32'hD7FF;
          6: cp = 32'hE000;
          7: cp = 32'hFFFF;
          8: cp = 32'h10000;
          default: cp = 32'h10FFFF;
        endcase
      end
    endcase
    return cp;
  endfunction

  function automatic void build_fragment();
    int          pick;
    int          n;
    logic [31:0] cp;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(1, 255));
        src_q.push_back(b);
      end
    end else if (pick < 45) begin
      src_q.push_back(CH_BSLASH);
      case ($urandom_range(0, 6))
        0: b = "n";
        1: b = "r";
        2: b = "t";
        3: b = CH_BSLASH;
        4: b = CH_APOS;
        5: b = CH_QUOTE;
        default: b = CH_NL;
      endcase
      src_q.push_back(b);
    end else if (pick < 58) begin
      src_q.push_back(CH_BSLASH);
      src_q.push_back("x");
      push_hex($urandom_range(0, 255), 2);
    end else if (pick < 82) begin
      if (pick < 78) begin
        cp = pick_code_point();
        n  = $urandom_range(min_digits(cp), MAX_HEX_DIGITS);
      end else begin
        cp = ($urandom_range(0, 1) == 1) ? $urandom_range(32'hD800, 32'hDFFF)
                                         : $urandom_range(32'h110000, 32'hFFFFFF);
        n  = min_digits(cp);
      end
      src_q.push_back(CH_BSLASH);
      src_q.push_back("u");
      src_q.push_back(CH_LBRACE);
      push_hex(cp, n);
      src_q.push_back(CH_RBRACE);
    end else if (pick < 85) begin
      src_q.push_back(CH_BSLASH);
      src_q.push_back("u");
      src_q.push_back(CH_LBRACE);
      push_hex($urandom, MAX_HEX_DIGITS + 1);
      src_q.push_back(CH_RBRACE);
    end else if (pick < 89) begin
      src_q.push_back(CH_BSLASH);
      case ($urandom_range(0, 4))
        0: begin
          src_q.push_back("u");
          b = 8'($urandom_range(0, 255));
          if (b == CH_LBRACE) b = "(";
          src_q.push_back(b);
        end
        1: begin
          src_q.push_back("u");
          src_q.push_back(CH_LBRACE);
          src_q.push_back(CH_RBRACE);
        end
        2: begin
          if ($urandom_range(0, 1) == 1) begin
            src_q.push_back("x");
            push_hex($urandom_range(0, 15), $urandom_range(0, 1));
          end else begin
            src_q.push_back("u");
            src_q.push_back(CH_LBRACE);
            push_hex($urandom_range(0, 32'hFFF), $urandom_range(0, 3));
          end
          b = 8'($urandom_range(0, 255));
          while (hex_val(b) >= 0) b = 8'($urandom_range(0, 255));
          src_q.push_back(b);
        end
        3: begin
          case ($urandom_range(0, 2))
            0: ;
            1: begin
              src_q.push_back("x");
              push_hex($urandom_range(0, 15), $urandom_range(0, 1));
            end
            default: begin
              src_q.push_back("u");
              src_q.push_back(CH_LBRACE);
              push_hex($urandom_range(0, 32'hFFFF), $urandom_range(0, 4));
            end
          endcase
          src_q.push_back(CH_NUL);
        end
        default: src_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end else if (pick < 94) begin
      src_q.push_back(CH_QUOTE);
    end else if (pick < 96) begin
      src_q.push_back(CH_NUL);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) src_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(stim_row_t row);
    int gap;
    gap = pick_wait(sent);
    @(negedge clk);
    if (gap > 0) begin
      body_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_if.valid   <= 1'b1;
    body_if.in_byte <= row.in_byte;
    @(posedge clk);
    while (!body_if.ready) @(posedge clk);
    sent++;
    decode_byte(row.in_byte);
    if (row.fixed) begin
      decoded_q.push_back({row.value, row.kind, 1'b1});
    end else begin
      foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    end
  endtask

  // result checking
  always @(posedge clk) begin
    utf8_res_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $error("result transfer with none pending: out_byte %h kind %0d last %0b",
               result_if.out_byte, result_if.kind, result_if.last);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (result_if.out_byte !== want.value) begin
          $error("out_byte: expected %h, got %h", want.value, result_if.out_byte);
          mismatches++;
        end
        if (result_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, result_if.kind);
          mismatches++;
        end
        if (result_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_if.last);
          mismatches++;
        end
      end
    end
  end

  // result receiver with one long hold-off
  initial begin
    int stall;
    int n;
    bit held;
    result_if.ready = 1'b0;
    n    = 0;
    held = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_wait(n);
      n++;
      if (!held && results_seen >= HOLD_OFF_AFTER) begin
        stall = HOLD_OFF_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
      while (!result_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("[string_escape_utf8_decoder] ERROR");
    $finish;
  end

  initial begin
    stim_row_t plan [26];
    int        k;
    rst             = 1'b1;
    body_if.valid   = 1'b0;
    body_if.in_byte = 8'h00;
    sent            = 0;
    results_seen    = 0;
    mismatches      = 0;
    scan_reset();

    plan = '{
      row_known(8'h41, 8'h41, KIND_DATA),
      row_known(8'hFF, 8'hFF, KIND_DATA),
      row_pred(CH_BSLASH), row_known("q", 8'h00, KIND_BAD),
      row_pred(CH_BSLASH), row_known(CH_NUL, 8'h00, KIND_BAD),
      row_pred(CH_BSLASH), row_pred("x"), row_pred("F"), row_pred("f"),
      row_pred(CH_BSLASH), row_pred("u"), row_pred(CH_LBRACE),
      row_known(CH_RBRACE, 8'h00, KIND_BAD),
      row_pred(CH_BSLASH), row_pred(CH_NL),
      row_pred(CH_BSLASH), row_pred("u"), row_pred(CH_LBRACE), row_pred("d"),
      row_pred("8"), row_pred("0"), row_pred("0"),
      row_known(CH_RBRACE, 8'h00, KIND_BAD),
      row_known(CH_QUOTE, 8'h00, KIND_OK),
      row_known(CH_NUL, 8'h00, KIND_UNTERM)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_byte(plan[i]);

    while (sent < ITEM_TARGET) begin
      build_fragment();
      while (src_q.size() > 0) send_byte(row_pred(src_q.pop_front()));
    end
    @(negedge clk);
    body_if.valid <= 1'b0;

    k = 0;
    while (decoded_q.size() > 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    if (decoded_q.size() > 0) begin
      $error("%0d decoded results never arrived", decoded_q.size());
      mismatches++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[string_escape_utf8_decoder] OK");
    end else begin
      $display("[string_escape_utf8_decoder] ERROR");
    end
    $finish;
  end

endmodule
